### src/bfla_pkg.sv
`timescale 1ns / 1ps
package bfla_pkg;
   localparam int DEF_MAX_SLOTS = 1024;
   localparam logic [31:0] RST_POOL_BASE = 32'd0;
   localparam logic [10:0] RST_NUM_SLOTS = 11'd1024;
   localparam logic [16:0] RST_SLOT_BYTES = 17'd4096;

   localparam logic [1:0] CSR_POOL_BASE = 2'd0;
   localparam logic [1:0] CSR_NUM_SLOTS = 2'd1;
   localparam logic [1:0] CSR_SLOT_BYTES = 2'd2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE = 1'b1;

   localparam logic [2:0] ST_ALLOCATED = 3'd0;
   localparam logic [2:0] ST_EMPTY = 3'd1;
   localparam logic [2:0] ST_FREED = 3'd2;
   localparam logic [2:0] ST_OUTSIDE = 3'd3;
   localparam logic [2:0] ST_NOT_TAKEN = 3'd4;

   // controller -> datapath
   typedef struct packed {
      logic clear_start;
      logic clear_step;
      logic capture;
      logic read_head;
      logic mul_start;
      logic div_start;
      logic div_step;
      logic read_slot;
      logic commit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_done;
      logic div_done;
      logic is_free;
   } sts_type;
endpackage

### src/buffer_free_list_allocator_unit.sv
// Allocate: request accept, then states HEAD, MUL and DONE; DONE commits the response.
// Free: HEAD, DIV, SLOT, DONE; a 32-step restoring divider maps address to slot.
// One request in flight; next request accepted the cycle after the response is posted.
// A response still waiting in the output register holds the next commit.
// Reset (synchronous, active high) and csr writes to defined registers run a clearing
// pass over all MAX_SLOTS link entries; no request or csr write is accepted meanwhile.
`timescale 1ns / 1ps
module buffer_free_list_allocator_unit #(
   parameter int MAX_SLOTS = bfla_pkg::DEF_MAX_SLOTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [31:0] req_buffer_addr,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_granted_addr,
   output logic [63:0] rsp_alloc_total,
   output logic [63:0] rsp_free_total,
   output logic [63:0] rsp_fail_total,
   output logic [10:0] rsp_in_use_now,
   output logic [10:0] rsp_peak_in_use,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import bfla_pkg::*;

   logic [31:0] pool_base_ff;
   logic [10:0] num_slots_ff;
   logic [16:0] slot_bytes_ff;
   logic cfg_write;
   logic cfg_ready;
   cmd_type cmd;
   sts_type sts;

   assign csr_ready = cfg_ready;
   assign cfg_write = csr_valid && csr_ready && (csr_index == CSR_POOL_BASE ||
      csr_index == CSR_NUM_SLOTS || csr_index == CSR_SLOT_BYTES);

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff <= RST_POOL_BASE;
         num_slots_ff <= RST_NUM_SLOTS;
         slot_bytes_ff <= RST_SLOT_BYTES;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_POOL_BASE: pool_base_ff <= csr_data;
            CSR_NUM_SLOTS: num_slots_ff <= csr_data[10:0];
            CSR_SLOT_BYTES: slot_bytes_ff <= csr_data[16:0];
            default: ;
         endcase
      end
   end

   bfla_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .cfg_write, .cfg_ready, .sts, .cmd
   );

   bfla_datapath #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
      .clock, .reset, .cmd, .sts,
      .pool_base(pool_base_ff), .num_slots(num_slots_ff), .slot_bytes(slot_bytes_ff),
      .req_opcode, .req_buffer_addr, .rsp_status, .rsp_granted_addr,
      .rsp_alloc_total, .rsp_free_total, .rsp_fail_total,
      .rsp_in_use_now, .rsp_peak_in_use
   );

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> !req_ready) else $error("request taken during clear");
   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_ALLOCATED |-> rsp_granted_addr == 32'd0)
      else $error("granted address on failed op");
   a_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_peak_in_use >= rsp_in_use_now) else $error("peak below in use");
endmodule

### src/bfla_ctrl.sv
`timescale 1ns / 1ps
module bfla_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  logic cfg_write,
   output logic cfg_ready,
   input  bfla_pkg::sts_type sts,
   output bfla_pkg::cmd_type cmd
);
   import bfla_pkg::*;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_HEAD  = 7'b0000100,
      S_MUL   = 7'b0001000,
      S_DIV   = 7'b0010000,
      S_SLOT  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign cfg_ready = (state_ff == S_IDLE);
   assign req_ready = (state_ff == S_IDLE) && !cfg_write;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (cfg_write) begin
               cmd.clear_start = 1'b1;
               state_in = S_CLEAR;
            end else if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            cmd.read_head = 1'b1;
            if (sts.is_free) begin
               cmd.div_start = 1'b1;
               state_in = S_DIV;
            end else begin
               cmd.mul_start = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: state_in = S_DONE;
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = S_SLOT;
         end
         S_SLOT: begin
            cmd.read_slot = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

### src/bfla_datapath.sv
`timescale 1ns / 1ps
module bfla_datapath #(
   parameter int MAX_SLOTS = bfla_pkg::DEF_MAX_SLOTS
) (
   input  logic clock,
   input  logic reset,
   input  bfla_pkg::cmd_type cmd,
   output bfla_pkg::sts_type sts,
   input  logic [31:0] pool_base,
   input  logic [10:0] num_slots,
   input  logic [16:0] slot_bytes,
   input  logic        req_opcode,
   input  logic [31:0] req_buffer_addr,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_granted_addr,
   output logic [63:0] rsp_alloc_total,
   output logic [63:0] rsp_free_total,
   output logic [63:0] rsp_fail_total,
   output logic [10:0] rsp_in_use_now,
   output logic [10:0] rsp_peak_in_use
);
   import bfla_pkg::*;

   localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int LW = $clog2(MAX_SLOTS + 1);
   localparam logic [LW-1:0] EMPTY = LW'(MAX_SLOTS);

   logic [LW-1:0] link_mem [MAX_SLOTS];
   logic          taken_mem [MAX_SLOTS];

   logic [10:0] cnt_eff;
   logic [16:0] size_eff;
   always_comb begin
      if (num_slots == 11'd0) cnt_eff = 11'd1;
      else if ({21'd0, num_slots} > MAX_SLOTS) cnt_eff = 11'(MAX_SLOTS);
      else cnt_eff = num_slots;
      size_eff = (slot_bytes == 17'd0) ? 17'd1 : slot_bytes;
   end

   logic [IW-1:0] clr_idx_ff, clr_idx_in;
   logic [LW-1:0] head_ff, head_in;
   logic          op_ff;
   logic [31:0]   addr_ff;
   logic [IW-1:0] idx_ff;
   logic [LW-1:0] link_rd_ff;
   logic          taken_rd_ff;
   logic          empty_ff;
   logic [31:0]   prod_ff;
   logic [27:0]   span_ff;
   logic [31:0]   quo_ff;
   logic [16:0]   rem_ff;
   logic [5:0]    div_cnt_ff;
   logic [63:0]   allocs_ff, frees_ff, fails_ff;
   logic [63:0]   allocs_in, frees_in, fails_in;
   logic [10:0]   cnt_ff, peak_ff;
   logic [10:0]   cnt_in, peak_in;
   logic [2:0]    status_ff, status_in;
   logic [31:0]   granted_ff, granted_in;
   logic [63:0]   o_alloc_ff, o_free_ff, o_fail_ff;
   logic [10:0]   o_cnt_ff, o_peak_ff;

   assign clr_idx_in = clr_idx_ff + IW'(1);
   assign sts.clear_done = (clr_idx_ff == IW'(MAX_SLOTS - 1));
   assign sts.div_done = (div_cnt_ff == 6'd31);
   assign sts.is_free = (op_ff == OP_FREE);

   // remainder step of restoring division
   logic [17:0] trial;
   assign trial = {rem_ff, quo_ff[31]} - {1'b0, size_eff};

   logic out_of_pool, slot_ok;
   assign out_of_pool = {17'd0, addr_ff} >= {21'd0, span_ff};
   assign slot_ok = ({1'b0, quo_ff} < {22'd0, cnt_eff}) && taken_rd_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_start) clr_idx_ff <= '0;
      else if (cmd.clear_step) clr_idx_ff <= clr_idx_in;

      if (cmd.capture) begin
         op_ff <= req_opcode;
         addr_ff <= req_buffer_addr - pool_base;
         span_ff <= 28'(cnt_eff) * 28'(size_eff);
      end
      if (cmd.read_head) begin
         empty_ff <= (head_ff == EMPTY);
         idx_ff <= head_ff[IW-1:0];
         link_rd_ff <= link_mem[head_ff[IW-1:0]];
      end
      if (cmd.mul_start) prod_ff <= 32'(head_ff[IW-1:0]) * 32'(size_eff);
      if (cmd.div_start) begin
         quo_ff <= addr_ff;
         rem_ff <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + 6'd1;
         if (!trial[17]) begin
            rem_ff <= trial[16:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[15:0], quo_ff[31]};
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
      if (cmd.read_slot) begin
         idx_ff <= quo_ff[IW-1:0];
         taken_rd_ff <= ({1'b0, quo_ff} < {22'd0, cnt_eff}) ?
            taken_mem[quo_ff[IW-1:0]] : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         link_mem[clr_idx_ff] <= ({21'd0, clr_idx_ff} + 32'd1 < {21'd0, cnt_eff}) ?
            LW'(clr_idx_ff + IW'(1)) : EMPTY;
         taken_mem[clr_idx_ff] <= 1'b0;
      end else if (cmd.commit && op_ff == OP_ALLOC && !empty_ff) begin
         taken_mem[idx_ff] <= 1'b1;
      end else if (cmd.commit && op_ff == OP_FREE && !out_of_pool && slot_ok) begin
         taken_mem[idx_ff] <= 1'b0;
         link_mem[idx_ff] <= head_ff;
      end
   end

   always_comb begin
      head_in = head_ff;
      allocs_in = allocs_ff;
      frees_in = frees_ff;
      fails_in = fails_ff;
      cnt_in = cnt_ff;
      peak_in = peak_ff;
      status_in = ST_ALLOCATED;
      granted_in = '0;
      if (op_ff == OP_ALLOC) begin
         if (empty_ff) begin
            fails_in = fails_ff + 64'd1;
            status_in = ST_EMPTY;
         end else begin
            head_in = link_rd_ff;
            allocs_in = allocs_ff + 64'd1;
            cnt_in = cnt_ff + 11'd1;
            if (cnt_in > peak_ff) peak_in = cnt_in;
            granted_in = pool_base + prod_ff;
         end
      end else if (out_of_pool) begin
         status_in = ST_OUTSIDE;
      end else if (!slot_ok) begin
         status_in = ST_NOT_TAKEN;
      end else begin
         head_in = LW'(idx_ff);
         frees_in = frees_ff + 64'd1;
         if (cnt_ff != 11'd0) cnt_in = cnt_ff - 11'd1;
         status_in = ST_FREED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_start) begin
         head_ff <= '0;
         allocs_ff <= '0;
         frees_ff <= '0;
         fails_ff <= '0;
         cnt_ff <= '0;
         peak_ff <= '0;
      end else if (cmd.commit) begin
         head_ff <= head_in;
         allocs_ff <= allocs_in;
         frees_ff <= frees_in;
         fails_ff <= fails_in;
         cnt_ff <= cnt_in;
         peak_ff <= peak_in;
         status_ff <= status_in;
         granted_ff <= granted_in;
         o_alloc_ff <= allocs_in;
         o_free_ff <= frees_in;
         o_fail_ff <= fails_in;
         o_cnt_ff <= cnt_in;
         o_peak_ff <= peak_in;
      end
   end

   assign rsp_status = status_ff;
   assign rsp_granted_addr = granted_ff;
   assign rsp_alloc_total = o_alloc_ff;
   assign rsp_free_total = o_free_ff;
   assign rsp_fail_total = o_fail_ff;
   assign rsp_in_use_now = o_cnt_ff;
   assign rsp_peak_in_use = o_peak_ff;
endmodule

### verif/tb_buffer_free_list_allocator_unit.sv
`timescale 1ns / 1ps
module tb_buffer_free_list_allocator_unit;
   import bfla_pkg::*;

   localparam int SLOTS = DEF_MAX_SLOTS;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] granted;
      logic [63:0] allocs;
      logic [63:0] frees;
      logic [63:0] fails;
      logic [10:0] in_use;
      logic [10:0] peak;
   } alloc_rsp_type;

   class alloc_scoreboard;
      logic [31:0] base;
      logic [10:0] count_reg;
      logic [16:0] size_reg;
      int unsigned head;
      int unsigned link[SLOTS];
      bit taken[SLOTS];
      logic [63:0] allocs, frees, fails;
      int unsigned in_use, peak;
      alloc_rsp_type pending[$];
      int errors;

      function int unsigned eff_count();
         if (count_reg == 0) return 1;
         if (count_reg > SLOTS) return SLOTS;
         return count_reg;
      endfunction

      function int unsigned eff_size();
         return (size_reg == 0) ? 1 : size_reg;
      endfunction

      function void rebuild();
         int unsigned n;
         n = eff_count();
         for (int i = 0; i < SLOTS; i++) begin
            link[i] = (i + 1 < n) ? i + 1 : SLOTS;
            taken[i] = 0;
         end
         head = 0;
         allocs = 0; frees = 0; fails = 0; in_use = 0; peak = 0;
      endfunction

      function void init();
         base = RST_POOL_BASE;
         count_reg = RST_NUM_SLOTS;
         size_reg = RST_SLOT_BYTES;
         errors = 0;
         rebuild();
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] data);
         if (idx == CSR_POOL_BASE) base = data;
         else if (idx == CSR_NUM_SLOTS) count_reg = data[10:0];
         else if (idx == CSR_SLOT_BYTES) size_reg = data[16:0];
         else return;
         rebuild();
      endfunction

      function void note_request(logic op, logic [31:0] addr);
         alloc_rsp_type r;
         logic [31:0] offset;
         logic [63:0] span;
         int unsigned idx, sz, cnt;
         logic [63:0] g;
         sz = eff_size();
         cnt = eff_count();
         r.granted = 0;
         if (op == OP_ALLOC) begin
            if (head >= SLOTS) begin
               fails++;
               r.status = ST_EMPTY;
            end else begin
               idx = head;
               head = link[idx];
               taken[idx] = 1;
               allocs++;
               in_use++;
               if (in_use > peak) peak = in_use;
               g = 64'(base) + 64'(idx) * 64'(sz);
               r.granted = g[31:0];
               r.status = ST_ALLOCATED;
            end
         end else begin
            offset = addr - base;
            span = 64'(cnt) * 64'(sz);
            if (64'(offset) >= span) r.status = ST_OUTSIDE;
            else begin
               idx = offset / sz;
               if (idx >= cnt || !taken[idx]) r.status = ST_NOT_TAKEN;
               else begin
                  taken[idx] = 0;
                  link[idx] = head;
                  head = idx;
                  frees++;
                  if (in_use > 0) in_use--;
                  r.status = ST_FREED;
               end
            end
         end
         r.allocs = allocs;
         r.frees = frees;
         r.fails = fails;
         r.in_use = 11'(in_use);
         r.peak = 11'(peak);
         pending.push_back(r);
      endfunction

      function void check_response(alloc_rsp_type a);
         alloc_rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response, status %0d", $time, a.status);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.status !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, a.status);
            errors++;
         end
         if (a.granted !== e.granted) begin
            $display("%0t: granted_addr exp %h got %h", $time, e.granted, a.granted);
            errors++;
         end
         if (a.allocs !== e.allocs) begin
            $display("%0t: alloc_total exp %0d got %0d", $time, e.allocs, a.allocs);
            errors++;
         end
         if (a.frees !== e.frees) begin
            $display("%0t: free_total exp %0d got %0d", $time, e.frees, a.frees);
            errors++;
         end
         if (a.fails !== e.fails) begin
            $display("%0t: fail_total exp %0d got %0d", $time, e.fails, a.fails);
            errors++;
         end
         if (a.in_use !== e.in_use) begin
            $display("%0t: in_use_now exp %0d got %0d", $time, e.in_use, a.in_use);
            errors++;
         end
         if (a.peak !== e.peak) begin
            $display("%0t: peak_in_use exp %0d got %0d", $time, e.peak, a.peak);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_opcode;
   logic [31:0] req_buffer_addr;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_granted_addr;
   logic [63:0] rsp_alloc_total;
   logic [63:0] rsp_free_total;
   logic [63:0] rsp_fail_total;
   logic [10:0] rsp_in_use_now;
   logic [10:0] rsp_peak_in_use;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   alloc_scoreboard sb;
   int send_idle_pct;
   int recv_stall_pct;
   longint cycles;
   logic [31:0] granted_log[$];

   buffer_free_list_allocator_unit i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_buffer_addr(req_buffer_addr),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_granted_addr(rsp_granted_addr),
      .rsp_alloc_total(rsp_alloc_total),
      .rsp_free_total(rsp_free_total),
      .rsp_fail_total(rsp_fail_total),
      .rsp_in_use_now(rsp_in_use_now),
      .rsp_peak_in_use(rsp_peak_in_use),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > 2000000) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // response side: random stall, check on handshake
   always @(posedge clock) begin
      alloc_rsp_type a;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            a.status = rsp_status;
            a.granted = rsp_granted_addr;
            a.allocs = rsp_alloc_total;
            a.frees = rsp_free_total;
            a.fails = rsp_fail_total;
            a.in_use = rsp_in_use_now;
            a.peak = rsp_peak_in_use;
            if (rsp_status == ST_ALLOCATED) granted_log.push_back(rsp_granted_addr);
            sb.check_response(a);
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_request(logic op, logic [31:0] addr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_buffer_addr <= addr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(op, addr);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] data);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
      csr_valid <= 1'b0;
      granted_log.delete();
   endtask

   // address inside a granted slot in 75 percent of picks when one is known, else random, below base or past the pool
   function automatic logic [31:0] pick_free_addr();
      int k;
      logic [31:0] a;
      if (granted_log.size() != 0 && $urandom_range(99) < 75) begin
         k = $urandom_range(granted_log.size() - 1);
         a = granted_log[k];
         granted_log.delete(k);
         return a + $urandom_range(sb.eff_size() - 1);
      end
      case ($urandom_range(2))
         0: return $urandom();
         1: return sb.base - 1 - $urandom_range(15);
         default: return sb.base + 32'(64'(sb.eff_count()) * sb.eff_size());
      endcase
   endfunction

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 55) send_request(OP_ALLOC, $urandom());
         else send_request(OP_FREE, pick_free_addr());
      end
   endtask

   initial begin
      sb = new();
      sb.init();
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_ALLOC;
      req_buffer_addr = '0;
      csr_valid = 1'b0;
      csr_index = CSR_POOL_BASE;
      csr_data = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed, reset configuration
      send_request(OP_FREE, 32'h0000_0000);
      send_request(OP_ALLOC, 32'hFFFF_FFFF);
      send_request(OP_ALLOC, 32'h0);
      send_request(OP_FREE, 32'h0000_1FFF);
      send_request(OP_FREE, 32'h0000_1000);
      send_request(OP_FREE, 32'h0040_0000);
      send_request(OP_FREE, 32'hFFFF_FFFF);

      // tiny pool near top of address space, frees of wrapped addresses
      write_csr(CSR_POOL_BASE, 32'hFFFF_FFF0);
      write_csr(CSR_NUM_SLOTS, 32'd0);
      write_csr(CSR_SLOT_BYTES, 32'h0001_FFFF);
      send_request(OP_ALLOC, 32'h0);
      send_request(OP_ALLOC, 32'h0);
      send_request(OP_FREE, 32'hFFFF_FFEF);
      send_request(OP_FREE, 32'h0000_0005);
      send_request(OP_FREE, 32'h0000_0005);
      write_csr(CSR_NUM_SLOTS, 32'd3);
      write_csr(CSR_SLOT_BYTES, 32'd0);
      send_request(OP_ALLOC, 32'h0);
      send_request(OP_ALLOC, 32'h0);
      send_request(OP_ALLOC, 32'h0);
      send_request(OP_ALLOC, 32'h0);
      send_request(OP_FREE, 32'hFFFF_FFF1);
      send_request(OP_FREE, 32'hFFFF_FFF3);
      write_csr(CSR_NUM_SLOTS, 32'h7FF);
      write_csr(CSR_SLOT_BYTES, 32'h1_0000);
      send_request(OP_ALLOC, 32'h0);
      write_csr(CSR_NUM_SLOTS, 32'h3);

      send_idle_pct = 32;
      recv_stall_pct = 80;
      write_csr(CSR_POOL_BASE, $urandom());
      write_csr(CSR_SLOT_BYTES, $urandom_range(1, 300));
      write_csr(CSR_NUM_SLOTS, $urandom_range(2, 12));
      random_phase(150);
      drain();

      send_idle_pct = 80;
      recv_stall_pct = 32;
      write_csr(CSR_NUM_SLOTS, 32'd1024);
      write_csr(CSR_SLOT_BYTES, 32'd65536);
      write_csr(CSR_POOL_BASE, 32'h8000_0000);
      random_phase(150);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_csr(CSR_SLOT_BYTES, $urandom_range(1, 65536));
      write_csr(CSR_NUM_SLOTS, $urandom_range(1, 20));
      random_phase(150);

      drain();
      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

### files.f
src/bfla_pkg.sv
src/bfla_ctrl.sv
src/bfla_datapath.sv
src/buffer_free_list_allocator_unit.sv
verif/tb_buffer_free_list_allocator_unit.sv
